// ===== rtl/postfix_expression_evaluator_assert.svh =====
// Assertion macros shared by the checker files of the postfix evaluator.
// Holds only macro definitions; no dependencies.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PEE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/pee_pkg.sv =====
// Package for the postfix expression evaluator: constants, types, state codes.
// No dependencies.
package pee_pkg;
  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned STAT_W = 2;

  localparam logic [SYM_W-1:0] CH_ADD  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_SUB  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_MUL  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_DIV  = 8'h2F;
  localparam logic [SYM_W-1:0] CH_POW  = 8'h5E;
  localparam logic [SYM_W-1:0] CH_ZERO = 8'h30;

  localparam logic [STAT_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [STAT_W-1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ERR_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ERR_DIVZERO   = 2'd3;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_NONE} alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_Y, ST_RD_X, ST_WAIT, ST_LOAD, ST_ITER, ST_FIX, ST_PUSH,
    ST_FINAL_RD, ST_FINAL_WAIT, ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       take_in;    // latch symbol and last flag
    logic       rd_top;     // read stack top, pop it
    logic       cap_y;      // capture read data as right operand
    logic       cap_x;      // capture read data as left operand
    logic       load_unit;  // start divide or power
    logic       iter;       // one step of the iterative unit
    logic       fix;        // finish divide sign or power
    logic       push;       // push the result (or digit)
    logic       cap_res;    // capture final popped value
    logic       clear;      // clear stack and error after report
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_op;
    logic is_long;   // divide or power
    logic last;
    logic iter_done;
  } stat_t;
endpackage

// ===== rtl/pee_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/pee_ctrl.sv =====
// Controller state machine for the postfix evaluator.
// Depends on pee_pkg.
module pee_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  pee_pkg::stat_t stat,
  output pee_pkg::cmd_t  cmd
);
  pee_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pee_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pee_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = pee_pkg::ST_RD_Y;
      end
      pee_pkg::ST_RD_Y: begin
        if (stat.is_op) state_nxt = pee_pkg::ST_RD_X;
        else state_nxt = pee_pkg::ST_PUSH;
      end
      pee_pkg::ST_RD_X: state_nxt = pee_pkg::ST_WAIT;
      pee_pkg::ST_WAIT: begin
        if (stat.is_long) state_nxt = pee_pkg::ST_LOAD;
        else state_nxt = pee_pkg::ST_PUSH;
      end
      pee_pkg::ST_LOAD: state_nxt = pee_pkg::ST_ITER;
      pee_pkg::ST_ITER: begin
        if (stat.iter_done) state_nxt = pee_pkg::ST_FIX;
      end
      pee_pkg::ST_FIX: state_nxt = pee_pkg::ST_PUSH;
      pee_pkg::ST_PUSH: begin
        if (stat.last) state_nxt = pee_pkg::ST_FINAL_RD;
        else state_nxt = pee_pkg::ST_IDLE;
      end
      pee_pkg::ST_FINAL_RD: state_nxt = pee_pkg::ST_FINAL_WAIT;
      pee_pkg::ST_FINAL_WAIT: state_nxt = pee_pkg::ST_OUT;
      pee_pkg::ST_OUT: begin
        if (out_tready) state_nxt = pee_pkg::ST_IDLE;
      end
      default: state_nxt = pee_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      pee_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take_in = in_tvalid;
      end
      pee_pkg::ST_RD_Y: cmd.rd_top = stat.is_op;
      pee_pkg::ST_RD_X: begin
        cmd.rd_top = 1'b1;
        cmd.cap_y = 1'b1;
      end
      pee_pkg::ST_WAIT: cmd.cap_x = 1'b1;
      pee_pkg::ST_LOAD: cmd.load_unit = 1'b1;
      pee_pkg::ST_ITER: cmd.iter = 1'b1;
      pee_pkg::ST_FIX: cmd.fix = 1'b1;
      pee_pkg::ST_PUSH: cmd.push = 1'b1;
      pee_pkg::ST_FINAL_RD: cmd.rd_top = 1'b1;
      pee_pkg::ST_FINAL_WAIT: cmd.cap_res = 1'b1;
      pee_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        cmd.clear = out_tready;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/pee_dp.sv =====
// Datapath for the postfix evaluator: stack, ALU, shared divide/power unit.
// Depends on pee_pkg and pee_ram.
module pee_dp #(
  parameter int unsigned STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pee_pkg::SYM_W-1:0]    symbol,
  input  logic                         final_symbol,
  input  pee_pkg::cmd_t                cmd,
  output pee_pkg::stat_t               stat,
  output logic [pee_pkg::DATA_W-1:0]   value,
  output logic [pee_pkg::STAT_W-1:0]   status
);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = pee_pkg::DATA_W;
  localparam int unsigned IW = $clog2(DW + 1);

  logic [pee_pkg::SYM_W-1:0] sym_r;
  logic                      last_r;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [pee_pkg::STAT_W-1:0] err_r, err_nxt;
  logic [DW-1:0]             x_r, y_r;
  logic                      y_ok_r;
  logic [DW-1:0]             rdata;
  logic [AW-1:0]             raddr;
  logic                      we;
  logic [DW-1:0]             wdata;
  logic                      rd_ok;
  // Iterative unit: quotient/remainder for divide, result/base for power.
  logic [DW-1:0]             acc_r, aux_r, ex_r, sum_r;
  logic [IW-1:0]             it_r;
  logic                      neg_q_r;
  logic [DW-1:0]             res_r;
  logic [DW:0]               trial;
  logic [DW-1:0]             rem_sh;
  logic [DW-1:0]             push_val;
  logic                      is_div, is_pow, is_op;
  logic [DW-1:0]             val_r;
  logic [pee_pkg::STAT_W-1:0] stat_r;
  logic                      pow_phase_r;

  assign is_div = (sym_r == pee_pkg::CH_DIV);
  assign is_pow = (sym_r == pee_pkg::CH_POW);
  assign is_op  = (sym_r == pee_pkg::CH_ADD) || (sym_r == pee_pkg::CH_SUB) ||
                  (sym_r == pee_pkg::CH_MUL) || is_div || is_pow;
  assign stat.is_op = is_op;
  assign stat.is_long = is_div || is_pow;
  assign stat.last = last_r;
  assign stat.iter_done = (it_r == IW'(DW - 1)) && !(is_pow && !pow_phase_r);

  assign rd_ok = (cnt_r != '0);
  assign raddr = AW'(cnt_r - CW'(1));

  pee_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // Value to push: ALU result, unit result or digit.
  always_comb begin
    if (!is_op) begin
      push_val = DW'(sym_r) - DW'(pee_pkg::CH_ZERO);
    end else if (sym_r == pee_pkg::CH_ADD) begin
      push_val = x_r + y_r;
    end else if (sym_r == pee_pkg::CH_SUB) begin
      push_val = x_r - y_r;
    end else if (sym_r == pee_pkg::CH_MUL) begin
      push_val = x_r * y_r;
    end else begin
      push_val = res_r;
    end
  end

  assign we = cmd.push && (cnt_r < CW'(STACK_DEPTH));
  assign wdata = push_val;

  // Stack count and sticky error.
  always_comb begin
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
      err_nxt = pee_pkg::ERR_NONE;
    end else if (cmd.rd_top) begin
      if (rd_ok) cnt_nxt = cnt_r - CW'(1);
      else if (err_r == pee_pkg::ERR_NONE) err_nxt = pee_pkg::ERR_UNDERFLOW;
    end else if (cmd.push) begin
      if (we) cnt_nxt = cnt_r + CW'(1);
      else if (err_r == pee_pkg::ERR_NONE) err_nxt = pee_pkg::ERR_OVERFLOW;
    end else if (cmd.load_unit && is_div && y_r == '0) begin
      if (err_r == pee_pkg::ERR_NONE) err_nxt = pee_pkg::ERR_DIVZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= pee_pkg::ERR_NONE;
    end else begin
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

  // Input latch and operand capture; a failed pop gives zero.
  // The pop flag of each read is registered and used in the next cycle, with the read data.
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      sym_r <= symbol;
      last_r <= final_symbol;
    end
    if (cmd.rd_top) begin
      y_ok_r <= rd_ok;
    end
    if (cmd.cap_y) y_r <= y_ok_r ? rdata : '0;
    if (cmd.cap_x) x_r <= y_ok_r ? rdata : '0;
    if (cmd.cap_res) begin
      val_r <= y_ok_r ? rdata : '0;
      stat_r <= err_r;
    end
  end

  assign rem_sh = {aux_r[DW-2:0], acc_r[DW-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, ex_r};

  // Divide: restoring, one quotient bit a cycle on magnitudes.
  // Power: alternating multiply-by-base and square steps, one per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load_unit) begin
      it_r <= '0;
      pow_phase_r <= 1'b0;
      if (is_div) begin
        acc_r <= x_r[DW-1] ? -x_r : x_r;
        ex_r  <= y_r[DW-1] ? -y_r : y_r;
        aux_r <= '0;
        neg_q_r <= x_r[DW-1] ^ y_r[DW-1];
      end else begin
        acc_r <= DW'(1);
        aux_r <= x_r;
        ex_r  <= y_r;
        sum_r <= x_r;
      end
    end else if (cmd.iter) begin
      if (is_div) begin
        it_r <= it_r + IW'(1);
        acc_r <= {acc_r[DW-2:0], ~trial[DW]};
        aux_r <= trial[DW] ? rem_sh : trial[DW-1:0];
      end else if (!pow_phase_r) begin
        if (ex_r[0]) acc_r <= acc_r * aux_r;
        pow_phase_r <= 1'b1;
      end else begin
        aux_r <= aux_r * aux_r;
        ex_r <= ex_r >> 1;
        it_r <= it_r + IW'(1);
        pow_phase_r <= 1'b0;
      end
    end else if (cmd.fix) begin
      if (is_div) begin
        if (y_r == '0) res_r <= '0;
        else res_r <= neg_q_r ? -acc_r : acc_r;
      end else if (y_r[DW-1]) begin
        if (sum_r == DW'(1)) res_r <= DW'(1);
        else if (sum_r == '1) res_r <= y_r[0] ? '1 : DW'(1);
        else res_r <= '0;
      end else begin
        res_r <= acc_r;
      end
    end
  end

  assign value = val_r;
  assign status = stat_r;
endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
// Postfix evaluator: one character per word, one word in flight at a time.
// Between accepted words a digit is pushed, or + - * pop two operands and push the
// result; / and ^ also run the shared unit (one quotient bit a cycle for /, a
// multiply and a square per exponent bit for ^). A final character's result is then
// popped and its result word is valid in ST_OUT, holding the input off until accepted.
// Synchronous active-low reset empties the stack and clears the sticky error.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // final_symbol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [33:32] status, rest zero
);
  pee_pkg::cmd_t  cmd;
  pee_pkg::stat_t stat;
  logic [pee_pkg::DATA_W-1:0] value;
  logic [pee_pkg::STAT_W-1:0] status;

  pee_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .stat(stat), .cmd(cmd)
  );

  pee_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .symbol(in_tdata), .final_symbol(in_tlast),
    .cmd(cmd), .stat(stat), .value(value), .status(status)
  );

  assign out_tdata = {6'd0, status, value};
endmodule

// ===== rtl/pee_checker.sv =====
// Port-level checker for the postfix evaluator, bound to the top level.
// Depends on postfix_expression_evaluator_assert.svh.
`include "postfix_expression_evaluator_assert.svh"
module pee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  `PEE_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_tvalid, !in_tready, "input taken during output")
  `PEE_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output dropped")
  `PEE_ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "accepted twice in a row")
  `PEE_ASSERT_IMPL(a_pad, clk, rst_n, out_tvalid, out_tdata[39:34] == 6'd0, "pad bits set")
endmodule

bind postfix_expression_evaluator pee_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);

// ===== tb/postfix_expression_evaluator_test.sv =====
// Self-checking testbench for the postfix expression evaluator.
// Predicts each result from the characters sent and compares it with the result words.
// Depends on pee_pkg and the postfix_expression_evaluator RTL.
module postfix_expression_evaluator_test;

  typedef struct packed {
    logic [7:0] symbol;
    logic       final_symbol;
  } sym_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } eval_result_t;

  localparam int LIMIT_CYCLES = 1500000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  sym_word_t    pending_syms[$];
  eval_result_t expected_results[$];
  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;

  // Predictor state.
  logic [31:0] model_stack[pee_pkg::STACK_DEPTH_DEF];
  int          model_count;
  logic [1:0]  model_err;

  postfix_expression_evaluator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void note_error(logic [1:0] code);
    if (model_err == pee_pkg::ERR_NONE) model_err = code;
  endfunction

  function automatic void stack_push(logic [31:0] v);
    if (model_count >= pee_pkg::STACK_DEPTH_DEF) begin
      note_error(pee_pkg::ERR_OVERFLOW);
    end else begin
      model_stack[model_count] = v;
      model_count++;
    end
  endfunction

  function automatic logic [31:0] stack_pop();
    if (model_count == 0) begin
      note_error(pee_pkg::ERR_UNDERFLOW);
      return 32'd0;
    end
    model_count--;
    return model_stack[model_count];
  endfunction

  function automatic logic [31:0] int_power(logic [31:0] base, logic [31:0] ex);
    logic [31:0] r;
    logic [31:0] b;
    r = 32'd1;
    b = base;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    while (ex != 0) begin
      if (ex[0]) r = r * b;
      b = b * b;
      ex = ex >> 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] int_divide(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    if (b == 0) begin
      note_error(pee_pkg::ERR_DIVZERO);
      return 32'd0;
    end
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Applies one accepted character to the predictor and queues any result.
  function automatic void evaluate_symbol(sym_word_t w);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] v;
    eval_result_t res;
    if (w.symbol inside {pee_pkg::CH_ADD, pee_pkg::CH_SUB, pee_pkg::CH_MUL,
                         pee_pkg::CH_DIV, pee_pkg::CH_POW}) begin
      y = stack_pop();
      x = stack_pop();
      case (w.symbol)
        pee_pkg::CH_ADD: v = x + y;
        pee_pkg::CH_SUB: v = x - y;
        pee_pkg::CH_MUL: v = x * y;
        pee_pkg::CH_DIV: v = int_divide(x, y);
        default: v = int_power(x, y);
      endcase
      stack_push(v);
    end else begin
      stack_push({24'd0, w.symbol} - {24'd0, pee_pkg::CH_ZERO});
    end
    if (w.final_symbol) begin
      res.value = stack_pop();
      res.status = model_err;
      expected_results.push_back(res);
      model_count = 0;
      model_err = pee_pkg::ERR_NONE;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // Driver: offers the oldest pending character word and holds it until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        evaluate_symbol(pending_syms.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_syms.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_syms[0].symbol;
          in_tlast  <= pending_syms[0].final_symbol;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word and drives the receiver stalls.
  always @(posedge clk) begin
    eval_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      cycle_count++;
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[31:0] !== want.value)
            report_mismatch("value", out_tdata[31:0], want.value);
          if (out_tdata[33:32] !== want.status)
            report_mismatch("status", {30'd0, out_tdata[33:32]}, {30'd0, want.status});
          if (out_tdata[39:34] !== 6'd0)
            report_mismatch("pad", {26'd0, out_tdata[39:34]}, 32'd0);
        end
      end
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // Receiver hold-off counter.
  always @(posedge clk) begin
    if (rst_n && hold_off_cycles > 0) hold_off_cycles--;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic sym_word_t make_word(logic [7:0] s, logic f);
    sym_word_t w;
    w.symbol = s;
    w.final_symbol = f;
    return w;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(4, 0))
      0: return pee_pkg::CH_ADD;
      1: return pee_pkg::CH_SUB;
      2: return pee_pkg::CH_MUL;
      3: return pee_pkg::CH_DIV;
      default: return pee_pkg::CH_POW;
    endcase
  endfunction

  // Queues an expression whose operand count keeps it well-formed; operands are mostly digits, some random bytes.
  task automatic queue_expression(int operands);
    int depth;
    int pushed;
    int i;
    depth = 0;
    pushed = 0;
    while (pushed < operands || depth > 1) begin
      if (pushed < operands && (depth < 2 || $urandom_range(1, 0))) begin
        if ($urandom_range(3, 0) == 0)
          pending_syms.push_back(make_word(8'($urandom_range(255, 0)), 1'b0));
        else
          pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'($urandom_range(9, 0)),
                                           1'b0));
        pushed++;
        depth++;
      end else begin
        pending_syms.push_back(make_word(random_operator(), 1'b0));
        depth--;
      end
    end
    i = pending_syms.size() - 1;
    pending_syms[i].final_symbol = 1'b1;
  endtask

  task automatic wait_drained();
    while (pending_syms.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random(int n);
    int goal;
    goal = pending_syms.size() + n;
    while (pending_syms.size() < goal) begin
      case ($urandom_range(9, 0))
        0: pending_syms.push_back(make_word(8'($urandom_range(255, 0)),
                                            1'($urandom_range(1, 0))));
        1: pending_syms.push_back(make_word(random_operator(), 1'($urandom_range(1, 0))));
        default: queue_expression($urandom_range(6, 1));
      endcase
    end
  endtask

  initial begin
    int i;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    model_count = 0;
    model_err = pee_pkg::ERR_NONE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme symbols, each operator, and each error case.
    pending_syms.push_back(make_word(8'd0, 1'b1));
    pending_syms.push_back(make_word(8'd255, 1'b1));
    pending_syms.push_back(make_word(pee_pkg::CH_ADD, 1'b1));   // underflow on both operand pops
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd7, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd0, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_DIV, 1'b1));   // divide by zero
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd9, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd4, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_SUB, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd3, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_MUL, 1'b1));
    pending_syms.push_back(make_word(8'd47 - 8'd46, 1'b0));     // code 1 pushes -47
    pending_syms.push_back(make_word(8'd47, 1'b0));             // 47 is '/', not a digit
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd1, 1'b0));
    pending_syms.push_back(make_word(8'd255, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_POW, 1'b1));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd0, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd0, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_POW, 1'b1));   // zero to the zero
    // Base -1 with a negative odd exponent: (0 - 1) ^ (0 - 3).
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd0, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd1, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_SUB, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd0, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd3, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_SUB, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_POW, 1'b1));
    // Base 1 with a negative exponent: 1 ^ (0 - 2).
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd1, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd0, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd2, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_SUB, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_POW, 1'b1));
    // Overflow: 33 pushes onto a 32-deep stack.
    for (i = 0; i < 33; i++)
      pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd2, i == 32));
    wait_drained();
    repeat (80) @(posedge clk);

    // Most negative value divided by -1, built from digit codes.
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd2, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd9, 1'b0));
    pending_syms.push_back(make_word(8'd0, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ADD, 1'b0));   // 2, -39
    pending_syms.push_back(make_word(8'd0, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_SUB, 1'b0));   // 2, 9
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd4, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_SUB, 1'b0));   // 2, 5
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd5, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd4, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_SUB, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ADD, 1'b0));   // 2, 6
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd5, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_MUL, 1'b0));   // 2, 30
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd1, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ADD, 1'b0));   // 2, 31
    pending_syms.push_back(make_word(pee_pkg::CH_POW, 1'b0));   // 2^31
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd0, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_ZERO + 8'd1, 1'b0));
    pending_syms.push_back(make_word(pee_pkg::CH_SUB, 1'b0));   // 2^31, -1
    pending_syms.push_back(make_word(pee_pkg::CH_DIV, 1'b1));
    // A divide that underflows, then '.' pushes -2.
    pending_syms.push_back(make_word(8'd47, 1'b0));
    pending_syms.push_back(make_word(8'd47 - 8'd1, 1'b1));
    wait_drained();

    // Random phases with different idling.
    run_random(380);
    wait_drained();
    send_idle_pct = 61;
    run_random(380);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 61;
    run_random(380);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering.
    recv_stall_pct = 0;
    hold_off_cycles = 3000;
    run_random(150);
    wait_drained();
    send_idle_pct = 7;
    recv_stall_pct = 7;
    run_random(380);
    wait_drained();
    repeat (100) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pee_pkg.sv
rtl/pee_ram.sv
rtl/pee_ctrl.sv
rtl/pee_dp.sv
rtl/postfix_expression_evaluator.sv
rtl/pee_checker.sv
tb/postfix_expression_evaluator_test.sv
